// ===== hdl/prq_pkg.sv =====
// Shared constants and codes for the priority ready queue.
package prq_pkg;

    // Default storage depth and priority width of the ready list.
    localparam int DEPTH_DEF     = 64;
    localparam int PRIO_BITS_DEF = 3;

    // Fixed field widths.
    localparam int ID_W     = 6;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Command codes carried on the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Status codes returned with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

// ===== hdl/priority_ready_queue.sv =====
// Priority ready queue: a sorted list of process slots walked by one read/write port.
//
// The queue holds up to DEPTH process slots in ascending priority order, equal
// priorities first in, first out, in a single-port-write memory with a registered
// read. Each command is one transfer in and exactly one result transfer out. A push
// walks the list from the tail towards the head, moving each entry of larger
// priority number one place down until the insertion point is found; a pop or a
// remove walks from the head, finds the entry and moves every later entry one place
// up. Reads are issued one per cycle and the write of the entry read in the previous
// cycle overlaps the next read. A pop or a remove always walks the whole list, also
// after its entry is found; a push walks only until the insertion point is found.
// A push into an empty list, an unused command code and a full or empty case need
// no walk. The one memory read port visits each entry of a walk once. A result that
// finds the output register still full waits until it is free or being emptied. The
// input is not ready while a command is being worked on; a finished result waits in
// the output register, and the next command may be taken while it waits.
module priority_ready_queue #(
    parameter int DEPTH     = prq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [prq_pkg::CMD_W-1:0]      i_command,
    input  logic [prq_pkg::ID_W-1:0]       i_proc_id,
    input  logic [PRIO_BITS-1:0]           i_priority_req,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [prq_pkg::STATUS_W-1:0]   o_status,
    output logic [prq_pkg::ID_W-1:0]       o_out_id,
    output logic [PRIO_BITS-1:0]           o_out_priority,
    output logic [$clog2(DEPTH+1)-1:0]     o_queue_count
);
    import prq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ID_W + PRIO_BITS;

    // Sequencer states: idle, tail-first push walk, head-first pop/remove walk,
    // final write of a pushed entry at the head, and result hand-over.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PUSH = 5'b00010,
        S_REM  = 5'b00100,
        S_INS  = 5'b01000,
        S_RES  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_cmd                  r_cmd, n_cmd;
    logic [ID_W-1:0]       r_id, n_id;
    logic [PRIO_BITS-1:0]  r_pr, n_pr;

    // Read pipeline: address being read, and the address whose data is in r_rdata.
    logic [AW-1:0]         r_raddr, n_raddr;
    logic                  r_issue, n_issue;
    logic                  r_rvld;
    logic [AW-1:0]         r_daddr;
    logic [EW-1:0]         r_rdata;

    // Remove bookkeeping.
    logic                  r_found, n_found;
    logic [ID_W-1:0]       r_fid, n_fid;
    logic [PRIO_BITS-1:0]  r_fpr, n_fpr;

    // Result waiting for the output register.
    t_status               r_res_st, n_res_st;
    logic [ID_W-1:0]       r_res_id, n_res_id;
    logic [PRIO_BITS-1:0]  r_res_pr, n_res_pr;

    // Output register.
    logic                  r_ovld, n_ovld;
    t_status               r_ostatus, n_ostatus;
    logic [ID_W-1:0]       r_oid, n_oid;
    logic [PRIO_BITS-1:0]  r_opr, n_opr;
    logic [CW-1:0]         r_ocount, n_ocount;

    // Memory write port.
    logic                  w_en;
    logic [AW-1:0]         w_addr;
    logic [EW-1:0]         w_data;

    logic [EW-1:0]         r_mem [DEPTH];

    // Fields of the entry read in the previous cycle.
    logic [ID_W-1:0]       rd_id;
    logic [PRIO_BITS-1:0]  rd_pr;
    logic                  rd_last;
    logic                  rd_hit;

    assign rd_id   = r_rdata[EW-1 -: ID_W];
    assign rd_pr   = r_rdata[PRIO_BITS-1:0];
    assign rd_last = (r_daddr == AW'(r_count - 1'b1));
    assign rd_hit  = !r_found && ((r_cmd == CMD_POP) || (rd_id == r_id));

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovld;
    assign o_status       = r_ostatus;
    assign o_out_id       = r_oid;
    assign o_out_priority = r_opr;
    assign o_queue_count  = r_ocount;

    // List storage: up to one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[r_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_pr      = r_pr;
        n_raddr   = r_raddr;
        n_issue   = r_issue;
        n_found   = r_found;
        n_fid     = r_fid;
        n_fpr     = r_fpr;
        n_res_st  = r_res_st;
        n_res_id  = r_res_id;
        n_res_pr  = r_res_pr;
        n_ovld    = r_ovld;
        n_ostatus = r_ostatus;
        n_oid     = r_oid;
        n_opr     = r_opr;
        n_ocount  = r_ocount;
        w_en      = 1'b0;
        w_addr    = r_raddr;
        w_data    = r_rdata;

        // The waiting result leaves on its transfer.
        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_cmd'(i_command);
                    n_id     = i_proc_id;
                    n_pr     = i_priority_req;
                    n_found  = 1'b0;
                    n_res_st = ST_OK;
                    n_res_id = '0;
                    n_res_pr = '0;
                    unique case (i_command) inside
                        CMD_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_st = ST_FULL;
                                n_state  = S_RES;
                            end else if (r_count == '0) begin
                                n_raddr = '0;
                                n_state = S_INS;
                            end else begin
                                n_raddr = AW'(r_count - 1'b1);
                                n_issue = 1'b1;
                                n_state = S_PUSH;
                            end
                        end
                        CMD_POP, CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_st = (i_command == CMD_POP) ? ST_EMPTY : ST_NOTFOUND;
                                n_state  = S_RES;
                            end else begin
                                n_raddr = '0;
                                n_issue = 1'b1;
                                n_state = S_REM;
                            end
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end

            S_PUSH: begin
                // Walk from the tail; each entry behind the new one moves down a place.
                if (r_issue) begin
                    if (r_raddr == '0) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr - 1'b1;
                    end
                end
                if (r_rvld) begin
                    w_en   = 1'b1;
                    w_addr = AW'(r_daddr + 1'b1);
                    if (rd_pr > r_pr) begin
                        w_data = r_rdata;
                        if (r_daddr == '0) begin
                            n_issue = 1'b0;
                            n_raddr = '0;
                            n_state = S_INS;
                        end
                    end else begin
                        w_data  = {r_id, r_pr};
                        n_issue = 1'b0;
                        n_count = r_count + 1'b1;
                        n_state = S_RES;
                    end
                end
            end

            S_INS: begin
                // The new entry goes to the head, or into an empty list.
                w_en    = 1'b1;
                w_addr  = r_raddr;
                w_data  = {r_id, r_pr};
                n_count = r_count + 1'b1;
                n_state = S_RES;
            end

            S_REM: begin
                // Walk from the head; once the entry is found every later one moves up.
                if (r_issue) begin
                    if (r_raddr == AW'(r_count - 1'b1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr + 1'b1;
                    end
                end
                if (r_rvld) begin
                    if (r_found) begin
                        w_en   = 1'b1;
                        w_addr = r_daddr - 1'b1;
                        w_data = r_rdata;
                    end
                    if (rd_hit) begin
                        n_found = 1'b1;
                        n_fid   = rd_id;
                        n_fpr   = rd_pr;
                    end
                    if (rd_last) begin
                        n_issue = 1'b0;
                        n_state = S_RES;
                        if (r_found || rd_hit) begin
                            n_count  = r_count - 1'b1;
                            n_res_st = ST_OK;
                            n_res_id = rd_hit ? rd_id : r_fid;
                            n_res_pr = rd_hit ? rd_pr : r_fpr;
                        end else begin
                            n_res_st = ST_NOTFOUND;
                        end
                    end
                end
            end

            S_RES: begin
                // Load the output register once it is free or being emptied.
                if (!r_ovld || i_ready) begin
                    n_ovld    = 1'b1;
                    n_ostatus = r_res_st;
                    n_oid     = r_res_id;
                    n_opr     = r_res_pr;
                    n_ocount  = r_count;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_rvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_rvld  <= r_issue;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_pr      <= n_pr;
        r_raddr   <= n_raddr;
        r_daddr   <= r_raddr;
        r_found   <= n_found;
        r_fid     <= n_fid;
        r_fpr     <= n_fpr;
        r_res_st  <= n_res_st;
        r_res_id  <= n_res_id;
        r_res_pr  <= n_res_pr;
        r_ostatus <= n_ostatus;
        r_oid     <= n_oid;
        r_opr     <= n_opr;
        r_ocount  <= n_ocount;
    end

endmodule

// ===== dv/prq_list_checker.sv =====
// Watches both channels of the priority ready queue, predicts every result and compares it.
module prq_list_checker #(
    parameter int DEPTH     = prq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  logic                              i_cmd_ready,
    input  logic [prq_pkg::CMD_W-1:0]         i_command,
    input  logic [prq_pkg::ID_W-1:0]          i_proc_id,
    input  logic [PRIO_BITS-1:0]              i_priority_req,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [prq_pkg::STATUS_W-1:0]      i_status,
    input  logic [prq_pkg::ID_W-1:0]          i_out_id,
    input  logic [PRIO_BITS-1:0]              i_out_priority,
    input  logic [$clog2(DEPTH+1)-1:0]        i_queue_count,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import prq_pkg::*;

    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PRIO_BITS-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ID_W-1:0]      id;
        logic [PRIO_BITS-1:0] prio;
        logic [CNT_W-1:0]     count;
    } t_result;

    // Ready list in service order, and results still owed by the block.
    t_slot   ready_list[$];
    t_result owed_results[$];
    int      mismatches = 0;

    // Applies one command to the list and returns the result it must produce.
    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [ID_W-1:0] id,
                                              input logic [PRIO_BITS-1:0] prio);
        t_result res;
        t_slot   slot;
        int      pos;
        res.status = ST_OK;
        res.id     = '0;
        res.prio   = '0;
        unique case (cmd)
            CMD_PUSH: begin
                if (ready_list.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // Goes behind every entry of equal or lower priority number.
                    pos = 0;
                    while (pos < ready_list.size() && ready_list[pos].prio <= prio)
                        pos++;
                    slot.id   = id;
                    slot.prio = prio;
                    ready_list.insert(pos, slot);
                end
            end
            CMD_POP: begin
                if (ready_list.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot     = ready_list.pop_front();
                    res.id   = slot.id;
                    res.prio = slot.prio;
                end
            end
            CMD_REMOVE: begin
                pos = -1;
                for (int i = 0; i < ready_list.size(); i++)
                    if (pos < 0 && ready_list[i].id == id)
                        pos = i;
                if (pos < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    res.id   = id;
                    res.prio = ready_list[pos].prio;
                    ready_list.delete(pos);
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(ready_list.size());
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            ready_list.delete();
            owed_results.delete();
        end else begin
            // A result leaving at this edge never belongs to a command taken at it.
            if (i_res_valid && i_res_ready) begin
                seen.status = i_status;
                seen.id     = i_out_id;
                seen.prio   = i_out_priority;
                seen.count  = i_queue_count;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%0t: unexpected result status=%0d id=%0d prio=%0d count=%0d",
                                 $realtime, seen.status, seen.id, seen.prio, seen.count);
                end else begin
                    want = owed_results.pop_front();
                    if (seen.status !== want.status || seen.id !== want.id ||
                        seen.prio !== want.prio || seen.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display("%0t: result mismatch, expected status=%0d id=%0d ",
                                     $realtime, want.status, want.id,
                                     "prio=%0d count=%0d, got status=%0d id=%0d ",
                                     want.prio, want.count, seen.status, seen.id,
                                     "prio=%0d count=%0d", seen.prio, seen.count);
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                owed_results.push_back(apply_command(i_command, i_proc_id, i_priority_req));
        end
        o_pending    <= owed_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the priority ready queue testbench: clock, reset, command stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prq_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int PRIO_BITS     = PRIO_BITS_DEF;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int TOTAL_ITEMS   = 1950;
    // The slowest correct run is roughly 1950 items times (gap + full walk + stall),
    // so this limit leaves a margin of several times.
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Command code 3 is not in the package enum; the block must treat it as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command      = '0;
    logic [ID_W-1:0]      i_proc_id      = '0;
    logic [PRIO_BITS-1:0] i_priority_req = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [ID_W-1:0]      o_out_id;
    logic [PRIO_BITS-1:0] o_out_priority;
    logic [CNT_W-1:0]     o_queue_count;

    int fail_count;
    int results_owed;
    int items_sent = 0;
    int cycles     = 0;

    // Shared between the stimulus and the result sink. A quiet side draws no gaps,
    // and a hold request makes the sink refuse results for a long stretch.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    priority_ready_queue #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_queue_count  (o_queue_count)
    );

    prq_list_checker #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) list_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_ready    (o_ready),
        .i_command      (i_command),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_status       (o_status),
        .i_out_id       (o_out_id),
        .i_out_priority (o_out_priority),
        .i_queue_count  (o_queue_count),
        .o_fail_count   (fail_count),
        .o_pending      (results_owed)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("priority_ready_queue regression: fail");
            $finish;
        end
    end

    // Offers one command and returns at the edge where its transfer happens. Valid is
    // only lowered when a gap is drawn, so back-to-back commands keep it high and
    // never see two assignments to it in one time step.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [ID_W-1:0] id,
                                input logic [PRIO_BITS-1:0] prio);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_proc_id      <= id;
        i_priority_req <= prio;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Sender pause: nothing is offered until every owed result has been transferred.
    // The checker's count is registered, so a stale read can only make the pause longer.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    // Most ids are drawn from a small pool so that removes usually find their target
    // and duplicate ids are common; the rest span the whole field.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    // Result sink: draws a stall for every result, and on request holds off for a long
    // stretch so that the output register fills and the block stops taking commands.
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int               phase_len;
        int               push_pct;
        int               roll;
        bit               first_phase;
        logic [CMD_W-1:0] cmd;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty list must report empty on pop and not found on
        // remove, and the unused code must leave everything alone.
        send_command(CMD_POP,    6'd0,  3'd0);
        send_command(CMD_REMOVE, 6'd5,  3'd0);
        send_command(CMD_UNUSED, 6'd63, 3'd7);
        // Extremes of id and priority, and ties at priority 7 that must stay in order.
        send_command(CMD_PUSH,   6'd63, 3'd7);
        send_command(CMD_PUSH,   6'd0,  3'd0);
        send_command(CMD_PUSH,   6'd42, 3'd7);
        send_command(CMD_PUSH,   6'd21, 3'd3);
        // The same id twice: a remove takes the first match in service order.
        send_command(CMD_PUSH,   6'd7,  3'd5);
        send_command(CMD_PUSH,   6'd7,  3'd2);
        send_command(CMD_REMOVE, 6'd7,  3'd0);
        send_command(CMD_REMOVE, 6'd5,  3'd0);
        send_command(CMD_UNUSED, 6'd42, 3'd5);
        send_command(CMD_REMOVE, 6'd21, 3'd0);
        // Drain in service order, then pop once more on an empty list.
        send_command(CMD_POP,    6'd0,  3'd0);
        send_command(CMD_POP,    6'd0,  3'd0);
        send_command(CMD_POP,    6'd0,  3'd0);
        send_command(CMD_POP,    6'd0,  3'd0);
        send_command(CMD_POP,    6'd0,  3'd0);
        // Single-entry list: remove and pop of the only entry.
        send_command(CMD_PUSH,   6'd1,  3'd4);
        send_command(CMD_REMOVE, 6'd1,  3'd0);
        send_command(CMD_PUSH,   6'd62, 3'd6);
        send_command(CMD_POP,    6'd0,  3'd0);
        wait_for_results();

        // Random part, in phases that lean towards filling, draining or a balance.
        // The first phase fills the list to full with the sink held off at its start,
        // and the contents carry over from phase to phase.
        first_phase = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            if (first_phase) begin
                push_pct    = 90;
                phase_len   = 150;
                tx_quiet    = 1'b1;
                rx_quiet    = 1'b0;
                hold_req    = 1'b1;
                first_phase = 1'b0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
                phase_len = $urandom_range(40, 160);
                tx_quiet  = ($urandom_range(0, 3) == 0);
                rx_quiet  = ($urandom_range(0, 3) == 0);
            end
            if (phase_len > TOTAL_ITEMS - items_sent)
                phase_len = TOTAL_ITEMS - items_sent;
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    cmd = CMD_UNUSED;
                else if (roll < 3 + push_pct)
                    cmd = CMD_PUSH;
                else if ($urandom_range(0, 1) == 0)
                    cmd = CMD_POP;
                else
                    cmd = CMD_REMOVE;
                send_command(cmd, pick_id(), PRIO_BITS'($urandom_range(0, (1 << PRIO_BITS) - 1)));
            end
            wait_for_results();
        end

        // Everything has been answered; give the block time to show any stray result.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0)
            $display("priority_ready_queue regression: pass");
        else
            $display("priority_ready_queue regression: fail");
        $finish;
    end

endmodule
